// File: sv/bone_global_transform_assert.svh
// ----------------------------------------------------------------------------
// Bone global transform assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BONE_GLOBAL_TRANSFORM_ASSERT_SVH
`define BONE_GLOBAL_TRANSFORM_ASSERT_SVH

// condition holds at every edge
`define BGT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define BGT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BGT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bgt_pkg.sv
// ----------------------------------------------------------------------------
// Bone global transform package
// Sizes, fixed-point constants and chain token types.
// ----------------------------------------------------------------------------
package bgt_pkg;

  localparam int MAX_BONES = 256;
  localparam int FRAC_BITS = 16;
  localparam int CNT_W     = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int CMP_W     = (CNT_W > 8) ? CNT_W : 8;
  localparam int RAM_DEPTH = MAX_BONES * 16;
  localparam int RAM_AW    = CNT_W + 4;
  localparam int ELEM_W    = 32;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = 66;
  localparam int NUM_REGS  = 8;

  localparam logic [NUM_REGS-1:0][63:0] WORLD_RST = {
    64'h0001_0000_0000_0000, 64'h0,
    64'h0000_0000_0001_0000, 64'h0,
    64'h0,                   64'h0001_0000_0000_0000,
    64'h0,                   64'h0000_0000_0001_0000
  };

  typedef logic [CNT_W-1:0] bone_t;

  // request context riding with each parent element down the chain
  typedef struct packed {
    logic       vld;
    logic [1:0] k;
    logic [1:0] j;
    bone_t      me;
    logic       bad;
    logic       last;
  } tok_t;

  // one finished global element
  typedef struct packed {
    logic              vld;
    logic [1:0]        j;
    logic [ELEM_W-1:0] val;
    logic              sat;
    bone_t             me;
    logic              bad;
    logic              last;
  } fin_t;

endpackage

// File: sv/bgt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bgt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/bgt_cell.sv
// ----------------------------------------------------------------------------
// Bone global transform row cell
// Multiplies one local row by the parent element stream, accumulates the
// four-term dot product, rounds and clamps each finished element.
// ----------------------------------------------------------------------------
module bgt_cell import bgt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  tok_t              tok_in,
  input  logic [ELEM_W-1:0] p_in,
  input  logic [127:0]      loc_row,
  output tok_t              tok_out,
  output logic [ELEM_W-1:0] p_out,
  output fin_t              fin
);

  localparam int SH_W = ACC_W - FRAC_BITS;
  localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SH_W-1:0] MAXV = {{(SH_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SH_W-1:0] MINV = {{(SH_W-31){1'b1}}, {31{1'b0}}};

  logic [127:0]             row_r, row_sel;
  logic                     first;
  logic signed [ELEM_W-1:0] l_el;
  tok_t                     a_tok_r;
  logic [ELEM_W-1:0]        p_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic                     b_done_r, b_bad_r, b_last_r;
  logic [1:0]               b_j_r;
  bone_t                    b_me_r;
  fin_t                     fin_r;
  logic [ACC_W-1:0]         rnd;
  logic signed [SH_W-1:0]   shv;

  assign first   = tok_in.vld && (tok_in.k == 2'd0) && (tok_in.j == 2'd0);
  assign row_sel = first ? loc_row : row_r;
  assign l_el    = $signed(row_sel[tok_in.k*ELEM_W +: ELEM_W]);

  assign acc_nxt = ((a_tok_r.k == 2'd0) ? '0 : acc_r)
                 + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  assign rnd = acc_r + RND;
  assign shv = $signed(rnd[ACC_W-1:FRAC_BITS]);

  // stage A: product and neighbor handoff
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tok_r.vld <= 1'b0;
    end else begin
      a_tok_r <= tok_in;
    end
    if (first) begin
      row_r <= loc_row;
    end
    p_r    <= p_in;
    prod_r <= l_el * $signed(p_in);
  end

  // stage B: accumulate over k
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_done_r <= 1'b0;
    end else begin
      b_done_r <= a_tok_r.vld && (a_tok_r.k == 2'd3);
    end
    if (a_tok_r.vld) begin
      acc_r <= acc_nxt;
    end
    b_j_r    <= a_tok_r.j;
    b_me_r   <= a_tok_r.me;
    b_bad_r  <= a_tok_r.bad;
    b_last_r <= a_tok_r.last;
  end

  // stage C: round to nearest, clamp to 32 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r.vld <= 1'b0;
    end else begin
      fin_r.vld <= b_done_r;
    end
    fin_r.j    <= b_j_r;
    fin_r.me   <= b_me_r;
    fin_r.bad  <= b_bad_r;
    fin_r.last <= b_last_r;
    if (shv > MAXV) begin
      fin_r.val <= 32'h7fff_ffff;
      fin_r.sat <= 1'b1;
    end else if (shv < MINV) begin
      fin_r.val <= 32'h8000_0000;
      fin_r.sat <= 1'b1;
    end else begin
      fin_r.val <= shv[ELEM_W-1:0];
      fin_r.sat <= 1'b0;
    end
  end

  assign tok_out = a_tok_r;
  assign p_out   = p_r;
  assign fin     = fin_r;

endmodule

// File: sv/bone_global_transform.sv
// ----------------------------------------------------------------------------
// Bone global transform
// Global = local * parent global (or world) in Q16.16, over a chain of cells.
// ----------------------------------------------------------------------------
// A new bone request can start as the previous one issues its last element:
// the parent matrix (from the global store or the world registers) is
// streamed one element per cycle through the store's single read port,
// column by column, down a chain of four row cells. Each cell owns one row
// of the local matrix and of the result; the element reaches cell i in the
// cycle after cell i-1, so the finished elements leave the cells one per
// cycle and go straight into the store and the result collector. On an idle
// block a request passes the input buffer, the sequencer, the issue register,
// the store read, the cell stages and the collector before out_valid rises.
// At most two bones are started and not yet delivered; with the output
// stalled one more request waits in the input buffer and then in_ready
// drops. World registers are 64-bit APB registers at byte address 8*i.
// ----------------------------------------------------------------------------
module bone_global_transform import bgt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // bone request
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_local_row0,
  input  logic [63:0] in_local_row0_hi,
  input  logic [63:0] in_local_row1,
  input  logic [63:0] in_local_row1_hi,
  input  logic [63:0] in_local_row2,
  input  logic [63:0] in_local_row2_hi,
  input  logic [63:0] in_local_row3,
  input  logic [63:0] in_local_row3_hi,
  input  logic        in_has_parent,
  input  logic [7:0]  in_parent_slot,
  input  logic        in_last_bone,
  // result
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_global_row0,
  output logic [63:0] out_global_row0_hi,
  output logic [63:0] out_global_row1,
  output logic [63:0] out_global_row1_hi,
  output logic [63:0] out_global_row2,
  output logic [63:0] out_global_row2_hi,
  output logic [63:0] out_global_row3,
  output logic [63:0] out_global_row3_hi,
  output logic [7:0]  out_bone_number,
  output logic        out_saturated,
  output logic        out_bad_parent,
  output logic        out_end_of_set
);

`include "bone_global_transform_assert.svh"

  // world registers
  logic [NUM_REGS-1:0][63:0] world_r;

  // input skid buffer
  logic                 buf_vld_r;
  logic [3:0][127:0]    buf_loc_r;
  logic                 buf_hp_r, buf_last_r;
  logic [7:0]           buf_slot_r;

  // current bone being streamed
  logic [3:0][127:0]    cur_loc_r;
  bone_t                cur_slot_r, cur_me_r, cnt_r;
  logic                 cur_use_r, cur_bad_r, cur_last_r;
  logic                 busy_r;
  logic [3:0]           t_r;
  logic [1:0]           pending_r;
  logic                 start, deliver, bad_nxt;
  logic [CMP_W-1:0]     slot_ext, cnt_ext, me_ext;

  // issue stage
  tok_t                 iss_tok_r;
  logic                 iss_use_r;
  logic [ELEM_W-1:0]    iss_w_r, rdata;
  logic [RAM_AW-1:0]    raddr, waddr;

  // chain
  tok_t                 tok [5];
  logic [ELEM_W-1:0]    pel [5];
  fin_t                 fin [4];
  logic [3:0]           fin_vld;

  // collector
  logic                 sel_vld;
  logic [1:0]           sel_i;
  fin_t                 sel;
  logic [15:0][31:0]    mat_r, out_mat_r;
  logic                 col_sat_r, col_bad_r, col_last_r, col_full_r, xfer;
  bone_t                col_me_r;
  logic                 out_vld_r, out_sat_r, out_bad_r, out_last_r;
  bone_t                out_me_r;

  // ---- config ----
  assign pready = 1'b1;
  assign prdata = world_r[paddr[5:3]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      world_r <= WORLD_RST;
    end else if (psel && penable && pwrite) begin
      world_r[paddr[5:3]] <= pwdata;
    end
  end

  // ---- input buffer and sequencer ----
  assign start    = buf_vld_r && (!busy_r || (t_r == 4'd15)) && (pending_r < 2'd2);
  assign in_ready = !buf_vld_r || start;
  assign deliver  = out_vld_r && out_ready;
  assign slot_ext = CMP_W'(buf_slot_r);
  assign cnt_ext  = CMP_W'(cnt_r);
  assign bad_nxt  = buf_hp_r && !(slot_ext < cnt_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      buf_vld_r <= 1'b1;
    end else if (start) begin
      buf_vld_r <= 1'b0;
    end
    if (in_valid && in_ready) begin
      buf_loc_r  <= {in_local_row3_hi, in_local_row3, in_local_row2_hi, in_local_row2,
                     in_local_row1_hi, in_local_row1, in_local_row0_hi, in_local_row0};
      buf_hp_r   <= in_has_parent;
      buf_slot_r <= in_parent_slot;
      buf_last_r <= in_last_bone;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      t_r       <= '0;
      cnt_r     <= '0;
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + {1'b0, start} - {1'b0, deliver};
      if (start) begin
        busy_r <= 1'b1;
        t_r    <= '0;
        if (buf_last_r || (CMP_W'(cnt_r) == CMP_W'(MAX_BONES - 1))) begin
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (busy_r) begin
        t_r <= t_r + 4'd1;
        if (t_r == 4'd15) begin
          busy_r <= 1'b0;
        end
      end
    end
    if (start) begin
      cur_loc_r  <= buf_loc_r;
      cur_slot_r <= slot_ext[CNT_W-1:0];
      cur_me_r   <= cnt_r;
      cur_use_r  <= buf_hp_r && !bad_nxt;
      cur_bad_r  <= bad_nxt;
      cur_last_r <= buf_last_r;
    end
  end

  // ---- issue: parent element P[k][j], j outer so columns finish in order ----
  assign raddr = {cur_slot_r, t_r[1:0], t_r[3:2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_tok_r.vld <= 1'b0;
    end else begin
      iss_tok_r.vld <= busy_r;
    end
    iss_tok_r.k    <= t_r[1:0];
    iss_tok_r.j    <= t_r[3:2];
    iss_tok_r.me   <= cur_me_r;
    iss_tok_r.bad  <= cur_bad_r;
    iss_tok_r.last <= cur_last_r;
    iss_use_r      <= cur_use_r;
    iss_w_r        <= world_r[{t_r[1:0], t_r[3]}][t_r[2]*ELEM_W +: ELEM_W];
  end

  bgt_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (sel_vld),
    .waddr (waddr),
    .wdata (sel.val),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign tok[0] = iss_tok_r;
  assign pel[0] = iss_use_r ? rdata : iss_w_r;

  for (genvar i = 0; i < 4; i++) begin : g_cell
    bgt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[i]),
      .p_in    (pel[i]),
      .loc_row (cur_loc_r[i]),
      .tok_out (tok[i+1]),
      .p_out   (pel[i+1]),
      .fin     (fin[i])
    );
    assign fin_vld[i] = fin[i].vld;
  end

  // cells finish on distinct cycles; pick the one that is valid
  always_comb begin
    sel_vld = 1'b0;
    sel_i   = 2'd0;
    sel     = fin[0];
    for (int i = 0; i < 4; i++) begin
      if (fin[i].vld) begin
        sel_vld = 1'b1;
        sel_i   = 2'(i);
        sel     = fin[i];
      end
    end
  end

  assign waddr = {sel.me, sel_i, sel.j};
  assign xfer  = col_full_r && (!out_vld_r || out_ready);

  // ---- collector and output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_full_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (xfer) begin
        col_full_r <= 1'b0;
      end
      if (sel_vld && (sel_i == 2'd3) && (sel.j == 2'd3)) begin
        col_full_r <= 1'b1;
      end
      if (xfer) begin
        out_vld_r <= 1'b1;
      end else if (deliver) begin
        out_vld_r <= 1'b0;
      end
    end
    if (sel_vld) begin
      mat_r[{sel_i, sel.j}] <= sel.val;
      col_sat_r  <= ((sel_i == 2'd0) && (sel.j == 2'd0)) ? sel.sat : (col_sat_r | sel.sat);
      col_me_r   <= sel.me;
      col_bad_r  <= sel.bad;
      col_last_r <= sel.last;
    end
    if (xfer) begin
      out_mat_r  <= mat_r;
      out_sat_r  <= col_sat_r;
      out_me_r   <= col_me_r;
      out_bad_r  <= col_bad_r;
      out_last_r <= col_last_r;
    end
  end

  assign me_ext             = CMP_W'(out_me_r);
  assign out_valid          = out_vld_r;
  assign out_global_row0    = {out_mat_r[1],  out_mat_r[0]};
  assign out_global_row0_hi = {out_mat_r[3],  out_mat_r[2]};
  assign out_global_row1    = {out_mat_r[5],  out_mat_r[4]};
  assign out_global_row1_hi = {out_mat_r[7],  out_mat_r[6]};
  assign out_global_row2    = {out_mat_r[9],  out_mat_r[8]};
  assign out_global_row2_hi = {out_mat_r[11], out_mat_r[10]};
  assign out_global_row3    = {out_mat_r[13], out_mat_r[12]};
  assign out_global_row3_hi = {out_mat_r[15], out_mat_r[14]};
  assign out_bone_number    = me_ext[7:0];
  assign out_saturated      = out_sat_r;
  assign out_bad_parent     = out_bad_r;
  assign out_end_of_set     = out_last_r;

  // ---- assertions ----
  `BGT_ASSERT_ALWAYS(a_fin_onehot, $onehot0(fin_vld), "two cells finished in one cycle")
  `BGT_ASSERT_IMP(a_no_overwrite, sel_vld, !col_full_r || xfer, "collector overrun")
  `BGT_ASSERT_ALWAYS(a_pending_max, pending_r != 2'd3, "too many bones in flight")
  `BGT_ASSERT_NXT(a_start_seq, start, busy_r && (t_r == 4'd0), "sequencer did not restart")

endmodule

// File: dv/tb_bone_global_transform.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bone global transform testbench
// Streams bone requests through the block, mirrors the hierarchy product in
// a local Q16.16 model and checks every result field against it, with
// random idle cycles on both channels and world matrix changes between
// phases.
// ----------------------------------------------------------------------------
module tb_bone_global_transform;
  import bgt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 1250;

  localparam logic signed [67:0] Q_MAX = 68'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [67:0] Q_MIN = -68'sh0_0000_0000_8000_0000;
  localparam logic signed [67:0] Q_HALF = 68'sd32768;

  typedef struct {
    logic [15:0][31:0] loc;
    logic              has_parent;
    logic [7:0]        slot;
    logic              last;
  } bone_req_t;

  typedef struct {
    logic [7:0][63:0] rows;
    logic [7:0]       bone;
    logic             sat;
    logic             bad;
    logic             last;
  } bone_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // config port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  // request channel
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0][63:0] in_rows = '0;
  logic        in_has_parent = 1'b0;
  logic [7:0]  in_parent_slot = '0;
  logic        in_last_bone = 1'b0;

  // result channel
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0][63:0] out_rows;
  logic [7:0]  out_bone_number;
  logic        out_saturated;
  logic        out_bad_parent;
  logic        out_end_of_set;

  bone_global_transform dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_local_row0      (in_rows[0]),
    .in_local_row0_hi   (in_rows[1]),
    .in_local_row1      (in_rows[2]),
    .in_local_row1_hi   (in_rows[3]),
    .in_local_row2      (in_rows[4]),
    .in_local_row2_hi   (in_rows[5]),
    .in_local_row3      (in_rows[6]),
    .in_local_row3_hi   (in_rows[7]),
    .in_has_parent      (in_has_parent),
    .in_parent_slot     (in_parent_slot),
    .in_last_bone       (in_last_bone),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_global_row0    (out_rows[0]),
    .out_global_row0_hi (out_rows[1]),
    .out_global_row1    (out_rows[2]),
    .out_global_row1_hi (out_rows[3]),
    .out_global_row2    (out_rows[4]),
    .out_global_row2_hi (out_rows[5]),
    .out_global_row3    (out_rows[6]),
    .out_global_row3_hi (out_rows[7]),
    .out_bone_number    (out_bone_number),
    .out_saturated      (out_saturated),
    .out_bad_parent     (out_bad_parent),
    .out_end_of_set     (out_end_of_set)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Hierarchy model: world registers, stored globals and the bone counter
  // ---------------------------------------------------------------------------
  logic [7:0][63:0] world_model = WORLD_RST;
  logic [31:0]      global_mem [MAX_BONES*16];
  int unsigned      bone_cnt = 0;

  bone_req_t request_q[$];
  bone_res_t global_q[$];

  int errors = 0;
  int n_sat = 0;
  int n_bad = 0;
  int n_child = 0;
  int n_results = 0;
  int wd_cnt = 0;
  bit calm = 1'b0;  // no idle cycles on either side while set

  function automatic logic [31:0] elem(logic [7:0][63:0] rows, int r, int c);
    logic [63:0] w;
    w = rows[2*r + c/2];
    return (c % 2) ? w[63:32] : w[31:0];
  endfunction

  // global = local * parent (or world); updates store and counter
  function automatic bone_res_t transform_bone(bone_req_t b);
    bone_res_t res;
    logic [31:0] par [16];
    logic [31:0] g [16];
    logic signed [67:0] acc;
    logic use_mem;
    int unsigned me;
    me = bone_cnt % MAX_BONES;
    use_mem = b.has_parent && (b.slot < me);
    res.bad = b.has_parent && !use_mem;
    res.sat = 1'b0;
    for (int i = 0; i < 16; i++)
      par[i] = use_mem ? global_mem[b.slot*16 + i] : elem(world_model, i/4, i%4);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        acc = '0;
        for (int k = 0; k < 4; k++)
          acc += longint'($signed(b.loc[r*4+k])) * longint'($signed(par[k*4+c]));
        acc = (acc + Q_HALF) >>> FRAC_BITS;
        if (acc > Q_MAX) begin
          g[r*4+c] = 32'h7FFF_FFFF;
          res.sat = 1'b1;
        end else if (acc < Q_MIN) begin
          g[r*4+c] = 32'h8000_0000;
          res.sat = 1'b1;
        end else begin
          g[r*4+c] = acc[31:0];
        end
      end
    for (int i = 0; i < 16; i++) global_mem[me*16 + i] = g[i];
    for (int r = 0; r < 4; r++) begin
      res.rows[2*r]   = {g[r*4+1], g[r*4]};
      res.rows[2*r+1] = {g[r*4+3], g[r*4+2]};
    end
    res.bone = me[7:0];
    res.last = b.last;
    bone_cnt = b.last ? 0 : (me + 1) % MAX_BONES;
    return res;
  endfunction

  function automatic logic [31:0] rand_elem();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return 32'($signed($urandom_range(0, 262143)) - 131072);
    if (pick == 6) return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic [7:0][63:0] rand_matrix();
    logic [7:0][63:0] m;
    for (int i = 0; i < 8; i++) m[i] = {rand_elem(), rand_elem()};
    return m;
  endfunction

  // predict and queue one request
  task automatic push_bone(bone_req_t b);
    bone_res_t res;
    res = transform_bone(b);
    request_q = {request_q, b};
    global_q  = {global_q, res};
  endtask

  // mostly well-formed hierarchies; some bad parents and stray roots
  task automatic push_random_bone(bit no_last);
    bone_req_t b;
    int unsigned pick;
    int unsigned me;
    me = bone_cnt % MAX_BONES;
    for (int i = 0; i < 16; i++) b.loc[i] = rand_elem();
    pick = $urandom_range(0, 9);
    b.slot = 8'($urandom);
    if (me > 0 && pick < 7) begin
      b.has_parent = 1'b1;
      b.slot = 8'($urandom_range(0, me - 1));
    end else if (pick < 8) begin
      b.has_parent = 1'b1;
      b.slot = 8'($urandom_range(me, 255));
    end else begin
      b.has_parent = 1'b0;
    end
    b.last = no_last ? 1'b0 : ($urandom_range(0, 11) == 0);
    push_bone(b);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || global_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 6'(idx * 8);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    world_model[idx] = val;
  endtask

  task automatic load_world(logic [7:0][63:0] m);
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) write_reg(i, m[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: presents queued bones with random idle cycles between them
  // ---------------------------------------------------------------------------
  int unsigned in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        bone_req_t b;
        b = request_q.pop_front();
        for (int r = 0; r < 4; r++) begin
          in_rows[2*r]   <= {b.loc[r*4+1], b.loc[r*4]};
          in_rows[2*r+1] <= {b.loc[r*4+3], b.loc[r*4+2]};
        end
        in_has_parent  <= b.has_parent;
        in_parent_slot <= b.slot;
        in_last_bone   <= b.last;
        in_valid       <= 1'b1;
        in_gap         <= calm ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random back-pressure, field-by-field compare
  // ---------------------------------------------------------------------------
  int unsigned out_stall = 0;

  always @(posedge clk) begin
    int unsigned next_stall;
    bone_res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      next_stall = (out_stall > 0) ? out_stall - 1 : 0;
      if (out_valid && out_ready) begin
        n_results++;
        if (global_q.size() == 0) begin
          $error("result for bone %0d with no request outstanding", out_bone_number);
          errors++;
        end else begin
          want = global_q.pop_front();
          for (int i = 0; i < 8; i++)
            if (out_rows[i] !== want.rows[i]) begin
              $error("global_row%0d%s: expected %h, got %h", i/2, (i%2) ? "_hi" : "",
                     want.rows[i], out_rows[i]);
              errors++;
            end
          if (out_bone_number !== want.bone) begin
            $error("bone_number: expected %0d, got %0d", want.bone, out_bone_number);
            errors++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated: expected %b, got %b", want.sat, out_saturated);
            errors++;
          end
          if (out_bad_parent !== want.bad) begin
            $error("bad_parent: expected %b, got %b", want.bad, out_bad_parent);
            errors++;
          end
          if (out_end_of_set !== want.last) begin
            $error("end_of_set: expected %b, got %b", want.last, out_end_of_set);
            errors++;
          end
          if (want.sat) n_sat++;
          if (want.bad) n_bad++;
        end
        next_stall = calm ? 0 : $urandom_range(0, 4);
      end
      out_stall <= next_stall;
      out_ready <= (next_stall == 0);
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      wd_cnt <= 0;
    end else if (wd_cnt >= WATCHDOG_LIMIT) begin
      $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      wd_cnt <= wd_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    bone_req_t b;
    logic [7:0][63:0] m;
    logic [31:0] fills [6];
    fills = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
              32'h0000_8000, 32'h0001_0000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: bad parent at bone 0 (slot equals counter), flat fills for
    // extremes and saturation, rounding ties, then a short random chain
    b.has_parent = 1'b1;
    b.slot = 8'd0;
    b.last = 1'b0;
    for (int i = 0; i < 16; i++) b.loc[i] = 32'h0001_0000;
    push_bone(b);
    for (int f = 0; f < 6; f++) begin
      for (int i = 0; i < 16; i++) b.loc[i] = fills[f];
      b.has_parent = 1'b0;
      b.slot = 8'hFF;
      push_bone(b);
      b.has_parent = 1'b1;
      b.slot = 8'(bone_cnt - 1);
      push_bone(b);
    end
    b.has_parent = 1'b1;
    b.slot = 8'hFF;   // far past the counter
    push_bone(b);
    for (int i = 0; i < 16; i++) b.loc[i] = 32'h0000_0001;
    b.has_parent = 1'b0;
    b.last = 1'b1;
    push_bone(b);
    // one-bone set, then a short chain that leaves the set open
    push_bone(b);
    for (int i = 0; i < 4; i++) push_random_bone(1'b1);
    wait_idle();

    // world: tie rounding (entries of plus and minus one half), then random phases
    for (int i = 0; i < 8; i++) m[i] = {32'h0000_8000, 32'hFFFF_8000};
    load_world(m);
    for (int i = 0; i < 20; i++) push_random_bone(1'b0);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: m = rand_matrix();
        1: for (int i = 0; i < 8; i++) m[i] = {32'h7FFF_FFFF, 32'h8000_0000};
        2: for (int i = 0; i < 8; i++) m[i] = {$urandom, $urandom};
        3: m = WORLD_RST;
        default: m = rand_matrix();
      endcase
      load_world(m);
      calm = (p == 2);
      if (p == 3) begin
        // long set without end marker so the counter wraps past 255
        for (int i = 0; i < 300; i++) push_random_bone(1'b1);
      end else begin
        for (int i = 0; i < (RANDOM_ITEMS - 300) / 4; i++) push_random_bone(1'b0);
      end
    end

    wait_idle();
    $display("checked %0d results: %0d child bones, %0d bad parents, %0d saturated,",
             n_results, n_child, n_bad, n_sat);
    $display("over 7 world matrices including identity, extremes and random fills");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // count bones that name a parent as they are accepted
  always @(posedge clk)
    if (rst_n && in_valid && in_ready && in_has_parent) n_child <= n_child + 1;

endmodule
